[hdl/snil_pkg.sv]
package snil_pkg;

  localparam logic [6:0]  POS_LIMIT    = 7'd106;
  localparam logic [6:0]  SAMPLE_LIMIT = 7'd100;
  localparam logic [7:0]  TICK_LIMIT   = 8'd200;
  localparam logic [9:0]  DUTY_MAX     = 10'd1023;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_INITIAL_DUTY   = 3'd0,
    REG_SAMPLE_TARGET  = 3'd1,
    REG_PRESET_NOISE   = 3'd2,
    REG_DUTY_STEP      = 3'd3,
    REG_DUTY_CEILING   = 3'd4,
    REG_TICKS_PER_STEP = 3'd5,
    REG_BENCH_ENABLE   = 3'd6,
    REG_BENCH_DUTY     = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [9:0]  initial_duty;
    logic [6:0]  noise_sample_target;
    logic [7:0]  preset_noise;
    logic [9:0]  duty_step;
    logic [9:0]  duty_ceiling;
    logic [7:0]  ticks_per_step;
    logic        bench_enable;
    logic [15:0] bench_duty;
  } cfg_t;

  typedef struct packed {
    op_t         opcode;
    logic        servo_enable;
    logic [15:0] cam_position;
    logic [15:0] pid_duty;
  } item_t;

  typedef struct packed {
    logic [9:0]  duty_out;
    logic        learning_done;
    logic        noise_ready;
    logic        integral_ready;
    logic [6:0]  noise_level;
    logic [15:0] integral_seed;
    logic [15:0] integral_snapshot;
    logic [9:0]  learning_duty;
  } result_t;

endpackage

[hdl/servo_noise_and_integral_learning.sv]
// channel  handshake            fields                                          direction
// -------  -------------------  ----------------------------------------------  ----------
// in       in_valid/in_ready    opcode, servo_enable, cam_position, pid_duty    to block
// out      out_valid/out_ready  duty_out, flags, noise, seed, snapshot, duty    from block
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data                             to block
//
// one item per cycle unless a result stalls on out_ready
// items pass the input register, then the one-register learning state loop in snil_learn
// the input register and the result register each hold while a result waits on out_ready
// rst (synchronous) clears the learning state and the stage valids and resets cfg
// cfg_ready is always high
module servo_noise_and_integral_learning (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic        servo_enable,
  input  logic [15:0] cam_position,
  input  logic [15:0] pid_duty,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  duty_out,
  output logic        learning_done,
  output logic        noise_ready,
  output logic        integral_ready,
  output logic [6:0]  noise_level,
  output logic [15:0] integral_seed,
  output logic [15:0] integral_snapshot,
  output logic [9:0]  learning_duty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  snil_pkg::cfg_t    cfg;
  snil_pkg::item_t   item;
  snil_pkg::result_t result;
  logic              item_valid;
  logic              advance;
  logic              step;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign step      = item_valid && advance;
  assign in_ready  = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_duty        <= '0;
      cfg.noise_sample_target <= '0;
      cfg.preset_noise        <= '0;
      cfg.duty_step           <= '0;
      cfg.duty_ceiling        <= snil_pkg::DUTY_MAX;
      cfg.ticks_per_step      <= '0;
      cfg.bench_enable        <= 1'b0;
      cfg.bench_duty          <= '0;
    end else if (cfg_valid) begin
      unique case (snil_pkg::reg_index_t'(cfg_index))
        snil_pkg::REG_INITIAL_DUTY:   cfg.initial_duty        <= cfg_data[9:0];
        snil_pkg::REG_SAMPLE_TARGET:  cfg.noise_sample_target <= cfg_data[6:0];
        snil_pkg::REG_PRESET_NOISE:   cfg.preset_noise        <= cfg_data[7:0];
        snil_pkg::REG_DUTY_STEP:      cfg.duty_step           <= cfg_data[9:0];
        snil_pkg::REG_DUTY_CEILING:   cfg.duty_ceiling        <= cfg_data[9:0];
        snil_pkg::REG_TICKS_PER_STEP: cfg.ticks_per_step      <= cfg_data[7:0];
        snil_pkg::REG_BENCH_ENABLE:   cfg.bench_enable        <= cfg_data[0];
        snil_pkg::REG_BENCH_DUTY:     cfg.bench_duty          <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (step) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.opcode       <= snil_pkg::op_t'(opcode);
      item.servo_enable <= servo_enable;
      item.cam_position <= cam_position;
      item.pid_duty     <= pid_duty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  snil_learn u_learn (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  assign duty_out          = result.duty_out;
  assign learning_done     = result.learning_done;
  assign noise_ready       = result.noise_ready;
  assign integral_ready    = result.integral_ready;
  assign noise_level       = result.noise_level;
  assign integral_seed     = result.integral_seed;
  assign integral_snapshot = result.integral_snapshot;
  assign learning_duty     = result.learning_duty;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !step)
    else $error("result overwritten while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("processed item produced no result");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid && $stable(item))
    else $error("stalled item lost");

endmodule

[hdl/snil_learn.sv]
module snil_learn (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  snil_pkg::item_t  item,
  input  snil_pkg::cfg_t   cfg,
  output snil_pkg::result_t result
);

  logic [9:0]  ramp_duty, ramp_duty_next;
  logic [7:0]  tick_counter, tick_counter_next;
  logic [6:0]  low_peak, low_peak_next;
  logic [6:0]  high_peak, high_peak_next;
  logic [6:0]  sample_counter, sample_counter_next;
  logic        noise_flag, noise_flag_next;
  logic        seed_flag, seed_flag_next;
  logic [6:0]  noise_value, noise_value_next;
  logic [15:0] seed_value, seed_value_next;
  logic [15:0] seed_snapshot, seed_snapshot_next;
  logic [9:0]  applied_duty, applied_duty_next;
  logic        done_flag, done_flag_next;

  logic [6:0]  pos_clamped;
  logic [6:0]  preset_clamped;
  logic        detect;
  logic [9:0]  backed;
  logic [10:0] ramp_sum;
  logic [15:0] duty_pick;

  always_comb begin
    ramp_duty_next      = ramp_duty;
    tick_counter_next   = tick_counter;
    low_peak_next       = low_peak;
    high_peak_next      = high_peak;
    sample_counter_next = sample_counter;
    noise_flag_next     = noise_flag;
    seed_flag_next      = seed_flag;
    noise_value_next    = noise_value;
    seed_value_next     = seed_value;
    seed_snapshot_next  = seed_snapshot;
    applied_duty_next   = applied_duty;
    done_flag_next      = done_flag;

    pos_clamped    = (item.cam_position > {9'd0, snil_pkg::POS_LIMIT}) ?
                     snil_pkg::POS_LIMIT : item.cam_position[6:0];
    preset_clamped = (cfg.preset_noise > {1'b0, snil_pkg::POS_LIMIT}) ?
                     snil_pkg::POS_LIMIT : cfg.preset_noise[6:0];
    detect   = 1'b0;
    backed   = '0;
    ramp_sum = '0;
    duty_pick = '0;

    if (item.opcode == snil_pkg::OP_RESTART) begin
      ramp_duty_next      = cfg.initial_duty;
      tick_counter_next   = '0;
      low_peak_next       = '0;
      high_peak_next      = '0;
      sample_counter_next = '0;
      noise_flag_next     = 1'b0;
      seed_flag_next      = 1'b0;
      seed_value_next     = '0;
    end else begin
      if (item.servo_enable) begin
        // noise tracking
        if (!noise_flag) begin
          if (sample_counter == '0) begin
            high_peak_next = pos_clamped;
            low_peak_next  = pos_clamped;
          end else begin
            if (item.cam_position > {9'd0, high_peak}) begin
              high_peak_next = pos_clamped;
            end
            low_peak_next = (pos_clamped < low_peak) ? pos_clamped : low_peak;
          end
          sample_counter_next = (sample_counter >= snil_pkg::SAMPLE_LIMIT) ?
                                snil_pkg::SAMPLE_LIMIT : sample_counter + 7'd1;
          if (sample_counter_next >= cfg.noise_sample_target) begin
            if (cfg.noise_sample_target == '0) begin
              noise_value_next = preset_clamped;
            end else if (high_peak_next >= low_peak_next) begin
              noise_value_next = high_peak_next - low_peak_next;
            end else begin
              noise_value_next = '0;
            end
            noise_flag_next = 1'b1;
          end
        end
        // duty ramp
        if (noise_flag_next && !seed_flag) begin
          detect = ({8'd0, noise_value_next, 1'b0} < item.cam_position) ||
                   (ramp_duty > cfg.duty_ceiling);
          if (detect) begin
            backed             = (ramp_duty > cfg.duty_step) ? ramp_duty - cfg.duty_step : '0;
            seed_flag_next     = 1'b1;
            seed_value_next    = {backed, 6'd0};
            seed_snapshot_next = {backed, 6'd0};
            ramp_duty_next     = backed;
          end else begin
            seed_flag_next     = 1'b0;
            seed_snapshot_next = seed_value;
            if (tick_counter < cfg.ticks_per_step) begin
              tick_counter_next = (tick_counter >= snil_pkg::TICK_LIMIT) ?
                                  snil_pkg::TICK_LIMIT : tick_counter + 8'd1;
            end else begin
              ramp_sum          = {1'b0, ramp_duty} + {1'b0, cfg.duty_step};
              ramp_duty_next    = ramp_sum[10] ? snil_pkg::DUTY_MAX : ramp_sum[9:0];
              tick_counter_next = '0;
            end
          end
        end
      end
      done_flag_next = noise_flag_next && seed_flag_next;
      if (item.servo_enable) begin
        if (cfg.bench_enable) begin
          duty_pick = cfg.bench_duty;
        end else if (seed_flag_next) begin
          duty_pick = item.pid_duty;
        end else begin
          duty_pick = {6'd0, ramp_duty_next};
        end
        applied_duty_next = (duty_pick[15:10] != '0) ? snil_pkg::DUTY_MAX : duty_pick[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_duty      <= '0;
      tick_counter   <= '0;
      low_peak       <= '0;
      high_peak      <= '0;
      sample_counter <= '0;
      noise_flag     <= 1'b0;
      seed_flag      <= 1'b0;
      noise_value    <= '0;
      seed_value     <= '0;
      seed_snapshot  <= '0;
      applied_duty   <= '0;
      done_flag      <= 1'b0;
    end else if (step) begin
      ramp_duty      <= ramp_duty_next;
      tick_counter   <= tick_counter_next;
      low_peak       <= low_peak_next;
      high_peak      <= high_peak_next;
      sample_counter <= sample_counter_next;
      noise_flag     <= noise_flag_next;
      seed_flag      <= seed_flag_next;
      noise_value    <= noise_value_next;
      seed_value     <= seed_value_next;
      seed_snapshot  <= seed_snapshot_next;
      applied_duty   <= applied_duty_next;
      done_flag      <= done_flag_next;
    end
  end

  assign result.duty_out          = applied_duty;
  assign result.learning_done     = done_flag;
  assign result.noise_ready       = noise_flag;
  assign result.integral_ready    = seed_flag;
  assign result.noise_level       = noise_value;
  assign result.integral_seed     = seed_value;
  assign result.integral_snapshot = seed_snapshot;
  assign result.learning_duty     = ramp_duty;

  a_noise_range: assert property (@(posedge clk) disable iff (rst)
    noise_value <= snil_pkg::POS_LIMIT)
    else $error("noise level above limit");

  a_seed_aligned: assert property (@(posedge clk) disable iff (rst)
    seed_value[5:0] == 6'd0)
    else $error("seed not a multiple of 64");

  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    tick_counter <= snil_pkg::TICK_LIMIT)
    else $error("tick counter above limit");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    sample_counter <= snil_pkg::SAMPLE_LIMIT && low_peak <= snil_pkg::POS_LIMIT &&
    high_peak <= snil_pkg::POS_LIMIT)
    else $error("noise tracking out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(ramp_duty) && $stable(seed_flag) && $stable(applied_duty))
    else $error("state moved without an item");

endmodule
